// ----- src/arith_symbol_decoder_macros.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef ARITH_SYMBOL_DECODER_MACROS_SVH
`define ARITH_SYMBOL_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define ASD_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);
`define ASD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASD_ASSERT(label, clk, rst_n, expr, msg)
`define ASD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ASD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/asd_pkg.sv -----
`timescale 1ns / 1ps
package asd_pkg;

    localparam int TABLE_DEPTH_DEF = 2048;

    localparam int REQ_W   = 2;
    localparam int IDX_W   = 11;
    localparam int WORD_W  = 15;
    localparam int LEN_W   = 2;
    localparam int WIN_W   = 16;
    localparam int SYM_W   = 5;
    localparam int USED_W  = 5;
    localparam int CODE_W  = 16;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_INIT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DECODE = 2'd2;

    // table length codes
    localparam logic [LEN_W-1:0] LEN_2  = 2'd0;
    localparam logic [LEN_W-1:0] LEN_4  = 2'd1;
    localparam logic [LEN_W-1:0] LEN_17 = 2'd2;
    localparam logic [LEN_W-1:0] LEN_27 = 2'd3;

    localparam logic [CODE_W-1:0] HALF     = 16'd32768;
    localparam logic [CODE_W-1:0] QUARTER  = 16'd16384;
    localparam logic [CODE_W-1:0] THREE_QT = 16'd49152;

    localparam logic [USED_W-1:0] WIN_BITS = 5'd16;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [IDX_W-1:0]  table_index;
        logic [WORD_W-1:0] table_word;
        logic [LEN_W-1:0]  length_code;
        logic [WIN_W-1:0]  bit_window;
    } asd_request_t;

    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [USED_W-1:0] bits_used;
        logic              window_short;
    } asd_result_t;

endpackage

// ----- src/asd_req_if.sv -----
`timescale 1ns / 1ps
interface asd_req_if;
    import asd_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [IDX_W-1:0]  table_index;
    logic [WORD_W-1:0] table_word;
    logic [LEN_W-1:0]  length_code;
    logic [WIN_W-1:0]  bit_window;

    modport source (
        output valid, req_type, table_index, table_word, length_code, bit_window,
        input  ready
    );

    modport sink (
        input  valid, req_type, table_index, table_word, length_code, bit_window,
        output ready
    );
endinterface

// ----- src/asd_res_if.sv -----
`timescale 1ns / 1ps
interface asd_res_if;
    import asd_pkg::*;

    logic              valid;
    logic              ready;
    logic [SYM_W-1:0]  symbol;
    logic [USED_W-1:0] bits_used;
    logic              window_short;

    modport source (
        output valid, symbol, bits_used, window_short,
        input  ready
    );

    modport sink (
        input  valid, symbol, bits_used, window_short,
        output ready
    );
endinterface

// ----- src/asd_freq_mem.sv -----
`timescale 1ns / 1ps
module asd_freq_mem #(
    parameter int TABLE_DEPTH = asd_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [asd_pkg::WORD_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [asd_pkg::WORD_W-1:0] rdata
);
    import asd_pkg::*;

    logic [WORD_W-1:0] mem_q [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[waddr] <= wdata;
        end
        rdata <= mem_q[raddr];
    end
endmodule

// ----- src/asd_engine.sv -----
`timescale 1ns / 1ps
`include "arith_symbol_decoder_macros.svh"
module asd_engine #(
    parameter int TABLE_DEPTH = asd_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  asd_pkg::asd_request_t      req,
    output logic                       res_valid,
    input  logic                       res_ready,
    output asd_pkg::asd_result_t       res,
    output logic                       mem_we,
    output logic [AW-1:0]              mem_waddr,
    output logic [asd_pkg::WORD_W-1:0] mem_wdata,
    output logic [AW-1:0]              mem_raddr,
    input  logic [asd_pkg::WORD_W-1:0] mem_rdata
);
    import asd_pkg::*;

    // index reduction: handles a quotient of an index by the depth below 2^(QB+1)
    localparam int QB   = IDX_W - 5;
    localparam int MODW = AW + QB + 1;
    localparam int SW   = AW + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ISSUE,
        S_MUL,
        S_CMP,
        S_N_ISSUE,
        S_N_LO,
        S_N_HI,
        S_N_FIN,
        S_RENORM,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [CODE_W-1:0]   lo_reg;
    logic [CODE_W-1:0]   hi_reg;
    logic [CODE_W-1:0]   val_reg;
    logic [AW-1:0]       base_reg;
    logic [LEN_W-1:0]    lc_reg;
    logic [WIN_W-1:0]    win_reg;
    logic signed [17:0]  rng_reg;
    logic signed [33:0]  c_reg;
    logic signed [33:0]  prod_reg;
    logic [CODE_W-1:0]   plo_reg;
    logic [SYM_W-1:0]    k_reg;
    logic [2:0]          step_reg;
    logic [USED_W-1:0]   used_reg;
    logic                short_reg;

    function automatic logic [AW-1:0] reduce_index(input logic [IDX_W-1:0] idx);
        logic [MODW-1:0] r;
        r = MODW'(idx);
        for (int j = QB; j >= 0; j--)
        begin
            if (r >= (MODW'(TABLE_DEPTH) << j))
            begin
                r = r - (MODW'(TABLE_DEPTH) << j);
            end
        end
        return AW'(r);
    endfunction

    function automatic logic [AW-1:0] table_addr(input logic [AW-1:0] base,
                                                 input logic [SYM_W-1:0] off);
        logic [SW-1:0] s;
        s = {1'b0, base} + SW'(off);
        if (s >= SW'(TABLE_DEPTH))
        begin
            s = s - SW'(TABLE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // search step sizes; a probe looks at k + add - 1
    function automatic logic [SYM_W-1:0] step_add(input logic [LEN_W-1:0] lc,
                                                  input logic [2:0] step);
        logic [SYM_W-1:0] a;
        a = 5'd1;
        unique case (step)
            3'd0:    a = (lc == LEN_27) ? 5'd16 : ((lc == LEN_4) ? 5'd2 : 5'd1);
            3'd1:    a = (lc == LEN_4) ? 5'd1 : 5'd8;
            3'd2:    a = 5'd4;
            3'd3:    a = 5'd2;
            default: a = 5'd1;
        endcase
        return a;
    endfunction

    function automatic logic step_last(input logic [LEN_W-1:0] lc, input logic [2:0] step);
        logic last;
        unique case (lc)
            LEN_2:   last = (step == 3'd0);
            LEN_4:   last = (step == 3'd1);
            default: last = (step == 3'd4);
        endcase
        return last;
    endfunction

    logic              accept;
    logic [SYM_W-1:0]  add;
    logic [SYM_W-1:0]  k_prev;
    logic signed [15:0] tbl_s;
    logic signed [33:0] prod_mul;
    logic              hit;
    logic              skip;
    logic signed [17:0] rng_init;
    logic signed [17:0] dist_init;
    logic signed [33:0] dist_ext;
    logic signed [33:0] c_init;
    logic              rn_go;
    logic [CODE_W-1:0] rn_sub;
    logic [CODE_W-1:0] lo_sub;
    logic [CODE_W-1:0] hi_sub;
    logic [CODE_W-1:0] val_sub;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    assign add    = step_add(lc_reg, step_reg);
    assign k_prev = (k_reg == '0) ? '0 : k_reg - 5'd1;
    assign tbl_s  = $signed({1'b0, mem_rdata});
    assign prod_mul = tbl_s * rng_reg;
    assign hit    = (prod_reg > c_reg);
    assign skip   = (lc_reg == LEN_27) &&
                    (((step_reg == 3'd2) && (k_reg == 5'd24)) ||
                     ((step_reg == 3'd4) && (k_reg == 5'd26)));

    assign rng_init  = $signed({2'b00, hi_reg}) - $signed({2'b00, lo_reg}) + 18'sd1;
    assign dist_init = $signed({2'b00, val_reg}) - $signed({2'b00, lo_reg}) + 18'sd1;
    assign dist_ext  = 34'(dist_init);
    assign c_init    = (dist_ext <<< 14) - 34'sd1;

    always_comb
    begin
        rn_go  = 1'b1;
        rn_sub = '0;
        priority if (hi_reg < HALF)
        begin
            rn_sub = '0;
        end
        else if (lo_reg >= HALF)
        begin
            rn_sub = HALF;
        end
        else if ((lo_reg >= QUARTER) && (hi_reg < THREE_QT))
        begin
            rn_sub = QUARTER;
        end
        else
        begin
            rn_go = 1'b0;
        end
    end

    assign lo_sub  = lo_reg - rn_sub;
    assign hi_sub  = hi_reg - rn_sub;
    assign val_sub = val_reg - rn_sub;

    assign mem_we    = accept && (req.req_type == REQ_WRITE);
    assign mem_waddr = reduce_index(req.table_index);
    assign mem_wdata = req.table_word;

    always_comb
    begin
        unique case (state_reg)
            S_ISSUE:   mem_raddr = table_addr(base_reg, k_reg + add - 5'd1);
            S_N_ISSUE: mem_raddr = table_addr(base_reg, k_reg);
            S_N_LO:    mem_raddr = table_addr(base_reg, k_prev);
            default:   mem_raddr = base_reg;
        endcase
    end

    assign res_valid = (state_reg == S_DONE);
    assign res       = '{symbol: k_reg, bits_used: used_reg, window_short: short_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lo_reg    <= '0;
            hi_reg    <= '1;
            val_reg   <= '0;
            k_reg     <= '0;
            step_reg  <= '0;
            used_reg  <= '0;
            short_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        k_reg     <= '0;
                        step_reg  <= '0;
                        short_reg <= 1'b0;
                        unique case (req.req_type)
                            REQ_INIT:
                            begin
                                lo_reg    <= '0;
                                hi_reg    <= '1;
                                val_reg   <= req.bit_window;
                                used_reg  <= WIN_BITS;
                                state_reg <= S_DONE;
                            end
                            REQ_DECODE:
                            begin
                                used_reg  <= '0;
                                state_reg <= S_ISSUE;
                            end
                            default:
                            begin
                                used_reg  <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_ISSUE:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (hit && !skip)
                    begin
                        k_reg <= k_reg + add;
                    end
                    // the 17-entry table stops at symbol zero when the first probe fails
                    priority if ((lc_reg == LEN_17) && (step_reg == 3'd0) && !hit)
                    begin
                        state_reg <= S_N_ISSUE;
                    end
                    else if (step_last(lc_reg, step_reg))
                    begin
                        state_reg <= S_N_ISSUE;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 3'd1;
                        state_reg <= S_ISSUE;
                    end
                end
                S_N_ISSUE:
                begin
                    state_reg <= S_N_LO;
                end
                S_N_LO:
                begin
                    state_reg <= S_N_HI;
                end
                S_N_HI:
                begin
                    state_reg <= S_N_FIN;
                end
                S_N_FIN:
                begin
                    if (k_reg != '0)
                    begin
                        hi_reg <= lo_reg + prod_reg[29:14] - 16'd1;
                    end
                    lo_reg    <= lo_reg + plo_reg;
                    state_reg <= S_RENORM;
                end
                S_RENORM:
                begin
                    priority if (!rn_go)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (used_reg == WIN_BITS)
                    begin
                        short_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        lo_reg   <= {lo_sub[14:0], 1'b0};
                        hi_reg   <= {hi_sub[14:0], 1'b1};
                        val_reg  <= {val_sub[14:0], win_reg[WIN_W-1]};
                        used_reg <= used_reg + 5'd1;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            base_reg <= reduce_index(req.table_index);
            lc_reg   <= req.length_code;
            win_reg  <= req.bit_window;
            rng_reg  <= rng_init;
            c_reg    <= c_init;
        end
        else if ((state_reg == S_RENORM) && rn_go)
        begin
            win_reg <= {win_reg[WIN_W-2:0], 1'b0};
        end

        if ((state_reg == S_MUL) || (state_reg == S_N_LO) || (state_reg == S_N_HI))
        begin
            prod_reg <= prod_mul;
        end
        // floor of (rng * tbl(k)) / 2^14, low 16 bits
        if (state_reg == S_N_HI)
        begin
            plo_reg <= prod_reg[29:14];
        end
    end

    `ASD_ASSERT(a_used_range, clk, rst_n, used_reg <= WIN_BITS, "bits used beyond window")
    `ASD_ASSERT_IMP(a_short_full, clk, rst_n, short_reg, used_reg == WIN_BITS,
                    "short flag without full window")
    `ASD_ASSERT_IMP(a_symbol_range, clk, rst_n, state_reg == S_DONE, k_reg <= 5'd26,
                    "symbol out of range")
    `ASD_ASSERT_NEXT(a_done_release, clk, rst_n, (state_reg == S_DONE) && res_ready,
                     state_reg == S_IDLE, "result handoff did not release engine")
endmodule

// ----- src/arith_symbol_decoder.sv -----
`timescale 1ns / 1ps
`include "arith_symbol_decoder_macros.svh"
// Arithmetic symbol decoder with 16-bit low/high/code registers and a table of
// TABLE_DEPTH cumulative frequency words (14-bit scale) in a synchronous memory;
// table addresses wrap at TABLE_DEPTH, and entries hold nothing until written.
// One request is processed at a time; the next request is taken as soon as the
// previous result has moved into the output register. A decode makes P search
// probes (1, 2, 5 or 5 for lengths 2, 4, 17, 27; a 17-entry search that fails its
// first probe stops after 1), then updates the interval and renormalizes: each
// probe is a memory read, a 15x18 multiply and a 34-bit compare, and
// renormalization shifts one stream bit per cycle.
module arith_symbol_decoder #(
    parameter int TABLE_DEPTH = asd_pkg::TABLE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    asd_req_if.sink   req,
    asd_res_if.source res
);
    import asd_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    asd_request_t      eng_req;
    logic              eng_res_valid;
    logic              eng_res_ready;
    asd_result_t       eng_res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    logic              out_valid_reg;
    asd_result_t       out_data_reg;

    assign eng_req = '{req_type:    req.req_type,
                       table_index: req.table_index,
                       table_word:  req.table_word,
                       length_code: req.length_code,
                       bit_window:  req.bit_window};

    asd_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req       (eng_req),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    asd_freq_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_freq_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register frees the engine while a result waits
    assign eng_res_ready = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_res_valid && eng_res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_res_valid && eng_res_ready)
        begin
            out_data_reg <= eng_res;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.symbol       = out_data_reg.symbol;
    assign res.bits_used    = out_data_reg.bits_used;
    assign res.window_short = out_data_reg.window_short;

    `ASD_ASSERT_NEXT(a_result_loaded, clk, rst_n, eng_res_valid && eng_res_ready,
                     out_valid_reg, "result not loaded into output register")
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import asd_pkg::*;

    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;   // unused kind; the block returns an empty result

    localparam int FREQ_SHIFT   = 14;
    localparam int FREQ_ONE     = 16384;
    localparam int RANDOM_ITEMS = 1350;
    localparam int DRAIN_CYCLES = 64;
    localparam int TIMEOUT_NS   = 8_000_000;

    typedef struct packed {
        logic         hold;     // wait for all results before presenting this request
        asd_request_t req;
    } pending_req_t;

    logic clk = 1'b0;
    logic rst_n;

    asd_req_if req_ch();
    asd_res_if res_ch();

    arith_symbol_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    always #5 clk = ~clk;

    pending_req_t      pending_reqs[$];
    asd_result_t       expected_results[$];
    asd_result_t       oldest_result;
    pending_req_t      next_req;
    asd_request_t      req_cur;

    // decoder state as predicted
    logic [CODE_W-1:0] pred_low;
    logic [CODE_W-1:0] pred_high;
    logic [CODE_W-1:0] pred_code;
    logic [WORD_W-1:0] pred_freq [TABLE_DEPTH_DEF];

    int          planned_items   = 0;
    int          mismatches      = 0;
    int          checked_results = 0;
    int          decode_count    = 0;
    int          short_count     = 0;
    logic [26:0] symbols_hit     = '0;
    logic [3:0]  lengths_hit     = '0;

    bit hold_next = 1'b0;
    int tbl_bases[$];
    int tbl_codes[$];

    bit req_busy  = 1'b0;
    bit req_taken = 1'b0;
    bit res_taken = 1'b0;
    int src_wait  = 0;
    int snk_wait  = 0;
    int src_count = 0;
    int snk_count = 0;

    function automatic int table_len(input int lc);
        case (lc)
            LEN_2:   return 2;
            LEN_4:   return 4;
            LEN_17:  return 17;
            default: return 27;
        endcase
    endfunction

    // idle-cycle draw; cycles through no-idle, uniform and bursty stretches
    function automatic int draw_wait(input int n);
        case ((n / 32) % 3)
            0:       return 0;
            1:       return $urandom_range(0, 12);
            default: return ($urandom_range(0, 7) == 0) ? 12 : $urandom_range(0, 2);
        endcase
    endfunction

    function automatic int rnd_word();
        case ($urandom_range(0, 7))
            0:       return FREQ_ONE;
            1:       return 0;
            default: return $urandom_range(0, FREQ_ONE - 1);
        endcase
    endfunction

    function automatic int rnd_window();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return 16'hFFFF;
            default: return $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    function automatic longint cum_word(input logic [IDX_W-1:0] base, input int off);
        return longint'(pred_freq[(int'(base) + off) % TABLE_DEPTH_DEF]);
    endfunction

    task automatic predict_request(input asd_request_t rq);
        asd_result_t       rs;
        longint            lo;
        longint            hi;
        longint            span;
        longint            thr;
        int                k;
        int                step;
        int                used;
        logic [CODE_W-1:0] l16;
        logic [CODE_W-1:0] h16;
        logic [CODE_W-1:0] v16;
        logic [CODE_W-1:0] sub;
        bit                stop;
        rs = '0;
        case (rq.req_type)
            REQ_INIT:
            begin
                pred_low     = '0;
                pred_high    = 16'hFFFF;
                pred_code    = rq.bit_window;
                rs.bits_used = WIN_BITS;
            end
            REQ_WRITE:
                pred_freq[int'(rq.table_index) % TABLE_DEPTH_DEF] = rq.table_word;
            REQ_DECODE:
            begin
                lo   = longint'(pred_low);
                hi   = longint'(pred_high);
                span = hi - lo + 1;
                thr  = (longint'(pred_code) - lo + 1) * FREQ_ONE - 1;
                k    = 0;
                case (rq.length_code)
                    LEN_2:
                        if (cum_word(rq.table_index, 0) * span > thr)
                            k = 1;
                    LEN_4:
                    begin
                        if (cum_word(rq.table_index, 1) * span > thr)
                            k = 2;
                        if (cum_word(rq.table_index, k) * span > thr)
                            k = k + 1;
                    end
                    LEN_17:
                        if (cum_word(rq.table_index, 0) * span > thr)
                        begin
                            k = 1;
                            for (step = 8; step >= 1; step = step / 2)
                                if (cum_word(rq.table_index, k - 1 + step) * span > thr)
                                    k = k + step;
                        end
                    default:
                    begin
                        // 27 entries: probes made when k is 24 or 26 are skipped, those are leaves
                        if (cum_word(rq.table_index, 15) * span > thr)
                            k = 16;
                        if (cum_word(rq.table_index, k + 7) * span > thr)
                            k = k + 8;
                        if (k != 24 && cum_word(rq.table_index, k + 3) * span > thr)
                            k = k + 4;
                        if (cum_word(rq.table_index, k + 1) * span > thr)
                            k = k + 2;
                        if (k != 26 && cum_word(rq.table_index, k) * span > thr)
                            k = k + 1;
                    end
                endcase

                if (k != 0)
                    hi = lo + ((span * cum_word(rq.table_index, k - 1)) >>> FREQ_SHIFT) - 1;
                lo = lo + ((span * cum_word(rq.table_index, k)) >>> FREQ_SHIFT);

                l16  = lo[CODE_W-1:0];
                h16  = hi[CODE_W-1:0];
                v16  = pred_code;
                used = 0;
                stop = 1'b0;
                while (!stop)
                begin
                    sub = '0;
                    if (h16 < HALF)
                        sub = '0;
                    else if (l16 >= HALF)
                        sub = HALF;
                    else if (l16 >= QUARTER && h16 < THREE_QT)
                        sub = QUARTER;
                    else
                        stop = 1'b1;
                    if (!stop)
                    begin
                        if (used >= int'(WIN_BITS))
                        begin
                            rs.window_short = 1'b1;
                            stop = 1'b1;
                        end
                        else
                        begin
                            l16  = l16 - sub;
                            h16  = h16 - sub;
                            v16  = v16 - sub;
                            l16  = {l16[CODE_W-2:0], 1'b0};
                            h16  = {h16[CODE_W-2:0], 1'b1};
                            v16  = {v16[CODE_W-2:0], rq.bit_window[WIN_W-1-used]};
                            used = used + 1;
                        end
                    end
                end

                pred_low     = l16;
                pred_high    = h16;
                pred_code    = v16;
                rs.symbol    = k[SYM_W-1:0];
                rs.bits_used = used[USED_W-1:0];

                decode_count = decode_count + 1;
                lengths_hit[rq.length_code] = 1'b1;
                symbols_hit[k] = 1'b1;
                if (rs.window_short)
                    short_count = short_count + 1;
            end
            default:
                ;
        endcase
        expected_results.push_back(rs);
    endtask

    task automatic compare_field(input string name, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            mismatches = mismatches + 1;
        end
    endtask

    task automatic queue_req(input logic [REQ_W-1:0] kind, input int idx, input int word,
                             input int lc, input int win);
        pending_req_t p;
        p.hold            = hold_next;
        p.req.req_type    = kind;
        p.req.table_index = idx[IDX_W-1:0];
        p.req.table_word  = word[WORD_W-1:0];
        p.req.length_code = lc[LEN_W-1:0];
        p.req.bit_window  = win[WIN_W-1:0];
        hold_next = 1'b0;
        pending_reqs.push_back(p);
        if (kind != REQ_NONE)
            planned_items = planned_items + 1;
    endtask

    // style 0: strictly falling cumulative words ending in zero
    // style 1: like 0 but with ties and unit steps (zero-width and tiny symbols)
    // style 2: arbitrary words
    task automatic write_table(input int base, input int len, input int style);
        int prev;
        int w;
        int i;
        prev = FREQ_ONE;
        for (i = 0; i < len; i++)
        begin
            if (style == 2)
                w = rnd_word();
            else if (i == len - 1)
                w = 0;
            else if (style == 1 && $urandom_range(0, 2) == 0)
                w = (prev > 0) ? prev - $urandom_range(0, 1) : 0;
            else
                w = $urandom_range(len - 1 - i, prev - 1);
            prev = w;
            queue_req(REQ_WRITE, (base + i) % TABLE_DEPTH_DEF, w, $urandom_range(0, 3),
                      rnd_window());
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        pred_low            = '0;
        pred_high           = 16'hFFFF;
        pred_code           = '0;
        req_cur             = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = '0;
        req_ch.table_index  = '0;
        req_ch.table_word   = '0;
        req_ch.length_code  = '0;
        req_ch.bit_window   = '0;
        res_ch.ready        = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL arith_symbol_decoder");
        $finish;
    end

    // request and result sides: accept at the rising edge, drive at the falling edge
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual symbol %0d bits %0d short %0b",
                         $time, res_ch.symbol, res_ch.bits_used, res_ch.window_short);
                mismatches = mismatches + 1;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                compare_field("symbol", oldest_result.symbol, res_ch.symbol);
                compare_field("bits_used", oldest_result.bits_used, res_ch.bits_used);
                compare_field("window_short", oldest_result.window_short, res_ch.window_short);
                checked_results = checked_results + 1;
            end
            res_taken = 1'b1;
        end
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            predict_request({req_ch.req_type, req_ch.table_index, req_ch.table_word,
                             req_ch.length_code, req_ch.bit_window});
            req_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_taken)
            begin
                req_taken = 1'b0;
                req_busy  = 1'b0;
                src_wait  = draw_wait(src_count);
                src_count = src_count + 1;
            end
            if (!req_busy)
            begin
                if (src_wait > 0)
                    src_wait = src_wait - 1;
                else if (pending_reqs.size() != 0
                         && !(pending_reqs[0].hold && expected_results.size() != 0))
                begin
                    next_req = pending_reqs.pop_front();
                    req_cur  = next_req.req;
                    req_busy = 1'b1;
                end
            end
            req_ch.valid       <= req_busy;
            req_ch.req_type    <= req_cur.req_type;
            req_ch.table_index <= req_cur.table_index;
            req_ch.table_word  <= req_cur.table_word;
            req_ch.length_code <= req_cur.length_code;
            req_ch.bit_window  <= req_cur.bit_window;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
            begin
                res_taken = 1'b0;
                snk_wait  = draw_wait(snk_count + 48);
                snk_count = snk_count + 1;
            end
            else if (snk_wait > 0)
                snk_wait = snk_wait - 1;
            res_ch.ready <= (snk_wait == 0);
        end
    end

    initial
    begin : stimulus
        int pick;
        int base;
        int sel;
        int runs;
        int i;
        int lc;

        // directed part
        queue_req(REQ_NONE, TABLE_DEPTH_DEF - 1, FREQ_ONE, LEN_27, 16'hFFFF);
        write_table(TABLE_DEPTH_DEF - 8, 27, 0);    // wraps past the top address
        tbl_bases.push_back(TABLE_DEPTH_DEF - 8);
        tbl_codes.push_back(LEN_27);
        queue_req(REQ_WRITE, 100, FREQ_ONE, LEN_2, 0);
        queue_req(REQ_WRITE, 101, FREQ_ONE / 2, LEN_2, 0);
        queue_req(REQ_WRITE, 102, FREQ_ONE / 2, LEN_2, 0);
        queue_req(REQ_INIT, 0, 0, LEN_2, 0);
        queue_req(REQ_DECODE, TABLE_DEPTH_DEF - 8, 0, LEN_27, rnd_window());  // last symbol
        queue_req(REQ_INIT, 0, 0, LEN_2, 16'hFFFF);
        queue_req(REQ_DECODE, TABLE_DEPTH_DEF - 8, 0, LEN_27, rnd_window());  // first symbol
        queue_req(REQ_INIT, 5, 9, LEN_4, rnd_window());
        queue_req(REQ_DECODE, TABLE_DEPTH_DEF - 1, 0, LEN_2, rnd_window());
        queue_req(REQ_DECODE, TABLE_DEPTH_DEF - 4, 0, LEN_4, rnd_window());
        queue_req(REQ_DECODE, TABLE_DEPTH_DEF - 8, 0, LEN_17, rnd_window());
        // zero-width symbol: decode a symbol of zero width, then decode from the renormalized interval
        queue_req(REQ_INIT, 0, 0, LEN_2, 0);
        queue_req(REQ_DECODE, 101, 0, LEN_2, 16'hFFFF);
        queue_req(REQ_DECODE, 100, 0, LEN_2, rnd_window());
        queue_req(REQ_INIT, 0, 0, LEN_2, 0);
        queue_req(REQ_DECODE, 100, FREQ_ONE, LEN_2, rnd_window());
        hold_next = 1'b1;

        // random part
        while (planned_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 149) == 0)
                hold_next = 1'b1;
            if (pick < 12)
            begin
                base = $urandom_range(0, TABLE_DEPTH_DEF - 1);
                lc   = $urandom_range(0, 3);
                write_table(base, table_len(lc), ($urandom_range(0, 9) < 6) ? 0 :
                            $urandom_range(1, 2));
                tbl_bases.push_back(base);
                tbl_codes.push_back(lc);
            end
            else if (pick < 20)
                queue_req(REQ_INIT, $urandom_range(0, TABLE_DEPTH_DEF - 1), rnd_word(),
                          $urandom_range(0, 3), rnd_window());
            else if (pick < 82)
            begin
                sel = $urandom_range(0, tbl_bases.size() - 1);
                if ($urandom_range(0, 1) == 0)
                    queue_req(REQ_INIT, $urandom_range(0, TABLE_DEPTH_DEF - 1), rnd_word(),
                              $urandom_range(0, 3), rnd_window());
                runs = $urandom_range(1, 10);
                for (i = 0; i < runs; i++)
                begin
                    lc = tbl_codes[sel];
                    // a shorter length reads only a prefix of the written table
                    if ($urandom_range(0, 3) == 0)
                        lc = $urandom_range(0, tbl_codes[sel]);
                    queue_req(REQ_DECODE, tbl_bases[sel], rnd_word(), lc, rnd_window());
                end
            end
            else if (pick < 92)
                queue_req(REQ_WRITE, $urandom_range(0, TABLE_DEPTH_DEF - 1), rnd_word(),
                          $urandom_range(0, 3), rnd_window());
            else
                queue_req(REQ_NONE, $urandom_range(0, TABLE_DEPTH_DEF - 1), rnd_word(),
                          $urandom_range(0, 3), rnd_window());
        end

        while (pending_reqs.size() != 0 || req_busy)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results, %0d of them decodes; %0d decodes ran out of window bits.",
                 checked_results, decode_count, short_count);
        $display("Table lengths seen (bit0=2 .. bit3=27): %b; symbols decoded: %b",
                 lengths_hit, symbols_hit);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS arith_symbol_decoder");
        else
            $display("FAIL arith_symbol_decoder");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/asd_pkg.sv
src/asd_req_if.sv
src/asd_res_if.sv
src/asd_freq_mem.sv
src/asd_engine.sv
src/arith_symbol_decoder.sv
dv/tb_top.sv
